/* hdl/pipeline_hazard_detector_unit_assert.svh */
// Assertion macros shared by the hazard detector modules.
`ifndef PIPELINE_HAZARD_DETECTOR_UNIT_ASSERT_SVH
`define PIPELINE_HAZARD_DETECTOR_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PHD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hazard detector check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hazard detector check failed");

`endif

/* hdl/phd_pkg.sv */
// Shared types and constants of the pipeline hazard detector.
`timescale 1ns / 1ps
package phd_pkg;

  localparam int unsigned PROGRAM_SIZE_DEF = 4096;
  localparam int unsigned OUT_IDX_W        = 12;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam logic [6:0]  LOAD_OPCODE      = 7'h03;

  typedef enum logic [2:0] {
    FMT_R     = 3'd0,
    FMT_I     = 3'd1,
    FMT_S     = 3'd2,
    FMT_B     = 3'd3,
    FMT_U     = 3'd4,
    FMT_J     = 3'd5,
    FMT_OTHER = 3'd6
  } fmt_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_CONTROL = 1'b1
  } kind_e;

  typedef struct packed {
    logic       first_of_program;
    logic [2:0] format;
    logic [4:0] dest_reg;
    logic [4:0] src1_reg;
    logic [4:0] src2_reg;
    logic [6:0] major_opcode;
  } phd_in_t;

  typedef struct packed {
    logic                 hazard_kind;
    logic [OUT_IDX_W-1:0] at_index;
    logic [OUT_IDX_W-1:0] with_index;
    logic                 last_of_run;
  } phd_out_t;

  // Records owed by one instruction, listed in emission order.
  typedef struct packed {
    logic data1;  // data hazard on the previous instruction
    logic data2;  // data hazard on the one before it
    logic ctrl3;  // branch three instructions back
    logic ctrl2;  // branch two instructions back
    logic ctrl1;  // branch one instruction back
  } phd_mask_t;

endpackage

/* hdl/phd_front.sv */
// Front end: accepts instructions, tracks history and classifies hazards.
`timescale 1ns / 1ps
module phd_front #(
  parameter int unsigned PROGRAM_SIZE = phd_pkg::PROGRAM_SIZE_DEF,
  localparam int unsigned IdxW = $clog2(PROGRAM_SIZE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fwd_en_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  phd_pkg::phd_in_t   in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output phd_pkg::phd_mask_t q_mask_o,
  output logic [IdxW-1:0]    q_idx_o
);
  import phd_pkg::*;

  localparam logic [IdxW:0] PsW = (IdxW + 1)'(PROGRAM_SIZE);

  logic [4:0]      dest1_q, dest2_q, dest1_d, dest2_d;
  logic            load1_q, load2_q, load1_d, load2_d;
  logic            br1_q, br2_q, br3_q, br1_d, br2_d, br3_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [4:0]      h_dest1, h_dest2;
  logic            h_load1, h_load2, h_br1, h_br2, h_br3;
  logic [IdxW-1:0] cur_idx;
  logic [IdxW:0]   idx_inc;
  logic [4:0]      s1, s2, dst;
  logic            hit1, hit2, accept;
  phd_mask_t       mask;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // A new program sees an empty history and starts at index zero.
  always_comb begin
    if (in_data_i.first_of_program) begin
      h_dest1 = '0;
      h_dest2 = '0;
      h_load1 = 1'b0;
      h_load2 = 1'b0;
      h_br1   = 1'b0;
      h_br2   = 1'b0;
      h_br3   = 1'b0;
      cur_idx = '0;
    end else begin
      h_dest1 = dest1_q;
      h_dest2 = dest2_q;
      h_load1 = load1_q;
      h_load2 = load2_q;
      h_br1   = br1_q;
      h_br2   = br2_q;
      h_br3   = br3_q;
      cur_idx = idx_q;
    end
  end

  always_comb begin
    s1  = '0;
    s2  = '0;
    dst = '0;
    case (in_data_i.format)
      FMT_R: begin
        s1  = in_data_i.src1_reg;
        s2  = in_data_i.src2_reg;
        dst = in_data_i.dest_reg;
      end
      FMT_I: begin
        s1  = in_data_i.src1_reg;
        dst = in_data_i.dest_reg;
      end
      FMT_S, FMT_B: begin
        s1 = in_data_i.src1_reg;
        s2 = in_data_i.src2_reg;
      end
      FMT_U, FMT_J: begin
        dst = in_data_i.dest_reg;
      end
      default: begin
      end
    endcase
  end

  assign hit1 = (s1 != '0 && s1 == h_dest1) || (s2 != '0 && s2 == h_dest1);
  assign hit2 = (s1 != '0 && s1 == h_dest2) || (s2 != '0 && s2 == h_dest2);

  always_comb begin
    mask.data1 = hit1 && (!fwd_en_i || h_load1);
    mask.data2 = hit2 && (!fwd_en_i || h_load2);
    mask.ctrl3 = h_br3;
    mask.ctrl2 = h_br2;
    mask.ctrl1 = h_br1;
  end

  assign q_push_o = accept && (mask != '0);
  assign q_mask_o = mask;
  assign q_idx_o  = cur_idx;

  assign idx_inc = {1'b0, cur_idx} + (IdxW + 1)'(1);

  always_comb begin
    dest1_d = dest1_q;
    dest2_d = dest2_q;
    load1_d = load1_q;
    load2_d = load2_q;
    br1_d   = br1_q;
    br2_d   = br2_q;
    br3_d   = br3_q;
    idx_d   = idx_q;
    if (accept) begin
      dest2_d = h_dest1;
      load2_d = h_load1;
      dest1_d = dst;
      load1_d = (in_data_i.major_opcode == LOAD_OPCODE);
      br3_d   = h_br2;
      br2_d   = h_br1;
      br1_d   = (in_data_i.format == FMT_B);
      idx_d   = (idx_inc == PsW) ? '0 : idx_inc[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest1_q <= '0;
      dest2_q <= '0;
      load1_q <= 1'b0;
      load2_q <= 1'b0;
      br1_q   <= 1'b0;
      br2_q   <= 1'b0;
      br3_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      dest1_q <= dest1_d;
      dest2_q <= dest2_d;
      load1_q <= load1_d;
      load2_q <= load2_d;
      br1_q   <= br1_d;
      br2_q   <= br2_d;
      br3_q   <= br3_d;
      idx_q   <= idx_d;
    end
  end

`include "pipeline_hazard_detector_unit_assert.svh"

  `PHD_ASSERT_NEXT(a_new_prog_idx, clk_i, rst_ni, accept && in_data_i.first_of_program, idx_q == IdxW'(1))
  `PHD_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, q_push_o, !q_full_i)

endmodule

/* hdl/phd_queue.sv */
// Small register queue between the front end and the record sequencer.
`timescale 1ns / 1ps
module phd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = phd_pkg::QUEUE_DEPTH,
  localparam int unsigned PtrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             full_o,
  output logic             empty_o
);
  import phd_pkg::*;

  localparam logic [PtrW:0] DepthW = (PtrW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthW);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`include "pipeline_hazard_detector_unit_assert.svh"

  `PHD_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= DepthW)
  `PHD_ASSERT_NEXT(a_cnt_track, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + (PtrW + 1)'(1))

endmodule

/* hdl/phd_back.sv */
// Back end: walks queued hazard masks, one record per cycle unless stalled.
`timescale 1ns / 1ps
module phd_back #(
  parameter int unsigned PROGRAM_SIZE = phd_pkg::PROGRAM_SIZE_DEF,
  localparam int unsigned IdxW = $clog2(PROGRAM_SIZE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  phd_pkg::phd_mask_t q_mask_i,
  input  logic [IdxW-1:0]    q_idx_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output phd_pkg::phd_out_t  out_data_o
);
  import phd_pkg::*;

  localparam logic [IdxW:0] PsW = (IdxW + 1)'(PROGRAM_SIZE);

  logic            work_valid_q, work_valid_d;
  phd_mask_t       rem_q, rem_d;
  logic [IdxW-1:0] widx_q, widx_d;
  logic            out_valid_q, out_valid_d;
  phd_out_t        out_q, out_d;

  phd_mask_t       pick, rest;
  logic [1:0]      back_dist;
  logic            kind, last, advance;
  logic [IdxW:0]   ext_idx, ext_dist, back_idx;
  logic [IdxW+OUT_IDX_W-1:0] at_x, with_x;

  // Lowest-numbered pending record goes first: data hazards nearest first,
  // then branches oldest first.
  always_comb begin
    pick      = '0;
    back_dist = 2'd1;
    kind      = KIND_DATA;
    if (rem_q.data1) begin
      pick.data1 = 1'b1;
      back_dist  = 2'd1;
    end else if (rem_q.data2) begin
      pick.data2 = 1'b1;
      back_dist  = 2'd2;
    end else if (rem_q.ctrl3) begin
      pick.ctrl3 = 1'b1;
      back_dist  = 2'd3;
      kind       = KIND_CONTROL;
    end else if (rem_q.ctrl2) begin
      pick.ctrl2 = 1'b1;
      back_dist  = 2'd2;
      kind       = KIND_CONTROL;
    end else begin
      pick.ctrl1 = 1'b1;
      back_dist  = 2'd1;
      kind       = KIND_CONTROL;
    end
  end

  assign rest = rem_q & ~pick;
  assign last = (rest == '0);

  // Index of the older instruction, wrapping at the program size.
  assign ext_idx  = {1'b0, widx_q};
  assign ext_dist = (IdxW + 1)'(back_dist);
  assign back_idx = (ext_idx < ext_dist) ? ext_idx + PsW - ext_dist : ext_idx - ext_dist;
  assign at_x     = (IdxW + OUT_IDX_W)'(widx_q);
  assign with_x   = (IdxW + OUT_IDX_W)'(back_idx[IdxW-1:0]);

  assign advance = !out_valid_q || out_ready_i;
  assign q_pop_o = !q_empty_i && (!work_valid_q || (advance && last));

  always_comb begin
    work_valid_d = work_valid_q;
    rem_d        = rem_q;
    widx_d       = widx_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    if (advance) begin
      out_valid_d = work_valid_q;
      if (work_valid_q) begin
        out_d.hazard_kind = kind;
        out_d.at_index    = at_x[OUT_IDX_W-1:0];
        out_d.with_index  = with_x[OUT_IDX_W-1:0];
        out_d.last_of_run = last;
        rem_d             = rest;
        work_valid_d      = !last;
      end
    end
    if (q_pop_o) begin
      work_valid_d = 1'b1;
      rem_d        = q_mask_i;
      widx_d       = q_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    widx_q <= widx_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "pipeline_hazard_detector_unit_assert.svh"

  `PHD_ASSERT_NOW(a_work_nonempty, clk_i, rst_ni, work_valid_q, rem_q != '0)
  `PHD_ASSERT_NOW(a_data_distinct, clk_i, rst_ni, out_valid_q && out_q.hazard_kind == KIND_DATA, out_q.at_index != out_q.with_index || PROGRAM_SIZE > 4096)

endmodule

/* hdl/pipeline_hazard_detector_unit.sv */
// Top level of the pipeline hazard detector: front end, queue, back end, register.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  --------------------------------
// in        input      in_valid_i/in_ready_o in_data_i  (phd_pkg::phd_in_t)
// out       output     out_valid_o/out_ready_i out_data_o (phd_pkg::phd_out_t)
// config    input      APB psel/penable      paddr, pwdata, prdata (one register)
//
// The front end classifies an instruction in the cycle its transfer completes and
// can take a new one every cycle while the hazard queue has room.
// The back end emits one record per cycle while the output is not stalled, so an
// instruction with n records takes n output slots; ones with none never reach it.
// Sustained rate is one instruction per cycle while the output is not stalled and
// instructions average at most one record each, a bound set by the back end's rate.
// Reset clears the history, the index, the queue and the forwarding register.
// A stalled output holds its record while the queue absorbs up to four more
// record-causing instructions before in_ready_o drops.
module pipeline_hazard_detector_unit #(
  parameter int unsigned PROGRAM_SIZE = phd_pkg::PROGRAM_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  phd_pkg::phd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output phd_pkg::phd_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import phd_pkg::*;

  localparam int unsigned IdxW  = $clog2(PROGRAM_SIZE);
  localparam int unsigned JobW  = $bits(phd_mask_t) + IdxW;

  // The only register sits at word index zero; other addresses are ignored.
  localparam logic REG_FWD_EN = 1'b0;

  logic            fwd_en_q, fwd_en_d;
  logic            cfg_wr;

  logic            q_push, q_pop, q_full, q_empty;
  phd_mask_t       f_mask, b_mask;
  logic [IdxW-1:0] f_idx, b_idx;
  logic [JobW-1:0] q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FWD_EN);
  assign prdata = (paddr[2] == REG_FWD_EN) ? {31'b0, fwd_en_q} : 32'b0;

  always_comb begin
    fwd_en_d = fwd_en_q;
    if (cfg_wr) begin
      fwd_en_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_en_q <= 1'b0;
    end else begin
      fwd_en_q <= fwd_en_d;
    end
  end

  // The front end pushes a hazard mask and the instruction index for every
  // instruction that causes at least one record.
  phd_front #(
    .PROGRAM_SIZE(PROGRAM_SIZE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fwd_en_i  (fwd_en_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_mask_o  (f_mask),
    .q_idx_o   (f_idx)
  );

  phd_queue #(
    .WIDTH(JobW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({f_mask, f_idx}),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  assign b_mask = q_head[JobW-1:IdxW];
  assign b_idx  = q_head[IdxW-1:0];

  // The back end turns each mask into its run of records, ending the run with
  // the last-of-run flag.
  phd_back #(
    .PROGRAM_SIZE(PROGRAM_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_mask_i   (b_mask),
    .q_idx_i    (b_idx),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
